@@ src/delta_list_sleep_queue_unit_defines.svh @@
// Assertion macros used by the sleep queue datapath.
`ifndef DELTA_LIST_SLEEP_QUEUE_UNIT_DEFINES_SVH
`define DELTA_LIST_SLEEP_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define DLSQ_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DLSQ_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/dlsq_pkg.sv @@
// Shared types, constants and control interfaces of the sleep queue.
`default_nettype none
package dlsq_pkg;

	localparam int DEF_QUEUE_DEPTH    = 16;
	localparam int DEF_TIME_BITS      = 32;
	localparam int DEF_THREAD_ID_BITS = 8;
	localparam int DUR_BITS           = 32;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_A_RD,
		ST_A_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_A_WR,
		ST_A_FULL,
		ST_T_CHK,
		ST_T_NEXT,
		ST_T_PEEK,
		ST_T_LAST
	} state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_HEAD,
		RD_POS,
		RD_SHIFT
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_SHIFT,
		WR_FIX,
		WR_NEW,
		WR_HEAD
	} wr_sel_t;

	typedef struct packed {
		logic    capture;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		logic    walk_step;
		logic    fix_save;
		logic    pop;
		logic    emit;
		logic    emit_last;
		logic    emit_full;
	} cmd_t;

	typedef struct packed {
		logic occ_zero;
		logic full;
		logic out_free;
		logic walk_ge;
		logic walk_last;
		logic shift_done;
		logic dec_one;
		logic peek_zero;
	} sts_t;

endpackage
`default_nettype wire

@@ src/dlsq_ram.sv @@
// Generic simple dual-port RAM with registered read data.
`default_nettype none
module dlsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/dlsq_ctrl.sv @@
// Controller state machine that sequences adds and ticks over the entry RAM.
`default_nettype none
module dlsq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          op,
	output logic               s_tready,
	input  wire dlsq_pkg::sts_t sts,
	output dlsq_pkg::cmd_t     cmd
);

	import dlsq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (op == OP_TICK) begin
						state_d = sts.occ_zero ? ST_IDLE : ST_T_CHK;
					end else if (sts.full) begin
						state_d = ST_A_FULL;
					end else begin
						state_d = sts.occ_zero ? ST_A_WR : ST_A_CMP;
					end
				end
			end
			ST_A_RD: state_d = ST_A_CMP;
			ST_A_CMP: begin
				if (sts.walk_ge) begin
					state_d = sts.walk_last ? ST_A_WR : ST_A_RD;
				end else begin
					state_d = ST_SH_RD;
				end
			end
			ST_SH_RD: state_d = sts.shift_done ? ST_A_WR : ST_SH_WR;
			ST_SH_WR: state_d = ST_SH_RD;
			ST_A_WR: state_d = ST_IDLE;
			ST_A_FULL: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_T_CHK: state_d = sts.dec_one ? ST_T_NEXT : ST_IDLE;
			ST_T_NEXT: state_d = sts.occ_zero ? ST_T_LAST : ST_T_PEEK;
			ST_T_PEEK: begin
				if (sts.out_free) begin
					state_d = sts.peek_zero ? ST_T_NEXT : ST_IDLE;
				end
			end
			ST_T_LAST: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		cmd = '{capture: 1'b0, rd_sel: RD_NONE, wr_sel: WR_NONE, walk_step: 1'b0,
			fix_save: 1'b0, pop: 1'b0, emit: 1'b0, emit_last: 1'b0, emit_full: 1'b0};
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
				// The head entry is fetched while the transaction is taken.
				if (s_tvalid && !sts.occ_zero) begin
					cmd.rd_sel = RD_HEAD;
				end
			end
			ST_A_RD: cmd.rd_sel = RD_POS;
			ST_A_CMP: begin
				cmd.walk_step = sts.walk_ge;
				cmd.fix_save  = !sts.walk_ge;
			end
			ST_SH_RD: begin
				if (sts.shift_done) begin
					cmd.wr_sel = WR_FIX;
				end else begin
					cmd.rd_sel = RD_SHIFT;
				end
			end
			ST_SH_WR: cmd.wr_sel = WR_SHIFT;
			ST_A_WR: cmd.wr_sel = WR_NEW;
			ST_A_FULL: begin
				cmd.emit      = sts.out_free;
				cmd.emit_last = 1'b1;
				cmd.emit_full = 1'b1;
			end
			ST_T_CHK: begin
				if (sts.dec_one) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.wr_sel = WR_HEAD;
				end
			end
			ST_T_NEXT: begin
				if (!sts.occ_zero) begin
					cmd.rd_sel = RD_HEAD;
				end
			end
			ST_T_PEEK: begin
				// The pending id is last unless the next entry also expires.
				cmd.emit      = sts.out_free;
				cmd.emit_last = !sts.peek_zero;
				cmd.pop       = sts.out_free && sts.peek_zero;
			end
			ST_T_LAST: begin
				cmd.emit      = sts.out_free;
				cmd.emit_last = 1'b1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

@@ src/dlsq_dp.sv @@
// Datapath: entry RAM, ring pointers, walk registers and the output register.
`default_nettype none
`include "delta_list_sleep_queue_unit_defines.svh"
module dlsq_dp #(
	parameter int QUEUE_DEPTH    = dlsq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS      = dlsq_pkg::DEF_TIME_BITS,
	parameter int THREAD_ID_BITS = dlsq_pkg::DEF_THREAD_ID_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire dlsq_pkg::cmd_t                cmd,
	output dlsq_pkg::sts_t                     sts,
	input  wire logic [THREAD_ID_BITS-1:0]     s_tid,
	input  wire logic [dlsq_pkg::DUR_BITS-1:0] s_dur,
	input  wire logic                          m_tready,
	output logic                               m_tvalid,
	output logic      [THREAD_ID_BITS-1:0]     m_tid,
	output logic                               m_last,
	output logic                               m_full
);

	import dlsq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = TIME_BITS + THREAD_ID_BITS;

	logic [AW-1:0]             head_q;
	logic [CW-1:0]             occ_q;
	logic [CW-1:0]             pos_q;
	logic [CW-1:0]             idx_q;
	logic [TIME_BITS-1:0]      dur_q;
	logic [THREAD_ID_BITS-1:0] tid_q;
	logic [THREAD_ID_BITS-1:0] wake_q;
	logic [EW-1:0]             fix_q;
	logic                      out_valid_q;
	logic [THREAD_ID_BITS-1:0] out_tid_q;
	logic                      out_last_q;
	logic                      out_full_q;

	logic [TIME_BITS-1:0]      dur_in;
	logic [TIME_BITS-1:0]      dur_norm;
	logic [EW-1:0]             rdata;
	logic [TIME_BITS-1:0]      rd_delta;
	logic [THREAD_ID_BITS-1:0] rd_owner;
	logic                      re;
	logic [CW-1:0]             rd_off;
	logic [AW-1:0]             raddr;
	logic                      we;
	logic [CW-1:0]             wr_off;
	logic [AW-1:0]             waddr;
	logic [EW-1:0]             wdata;
	logic                      out_free;

	// Maps a queue position to its RAM slot in the ring.
	function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
		input logic [CW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + (AW+1)'(off);
		if (sum >= (AW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (AW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign rd_delta = rdata[EW-1:THREAD_ID_BITS];
	assign rd_owner = rdata[THREAD_ID_BITS-1:0];

	// A zero duration sleeps for one tick.
	assign dur_in   = TIME_BITS'(s_dur);
	assign dur_norm = (dur_in == '0) ? TIME_BITS'(1) : dur_in;

	always_comb begin
		re     = 1'b0;
		rd_off = '0;
		case (cmd.rd_sel)
			RD_HEAD: re = 1'b1;
			RD_POS: begin
				re     = 1'b1;
				rd_off = pos_q;
			end
			RD_SHIFT: begin
				re     = 1'b1;
				rd_off = idx_q - CW'(1);
			end
			default: ;
		endcase
	end

	always_comb begin
		we     = 1'b0;
		wr_off = '0;
		wdata  = rdata;
		case (cmd.wr_sel)
			WR_SHIFT: begin
				we     = 1'b1;
				wr_off = idx_q;
			end
			WR_FIX: begin
				we     = 1'b1;
				wr_off = pos_q + CW'(1);
				wdata  = fix_q;
			end
			WR_NEW: begin
				we     = 1'b1;
				wr_off = pos_q;
				wdata  = {dur_q, tid_q};
			end
			WR_HEAD: begin
				we    = 1'b1;
				wdata = {rd_delta - TIME_BITS'(1), rd_owner};
			end
			default: ;
		endcase
	end

	assign raddr = ring_addr(head_q, rd_off);
	assign waddr = ring_addr(head_q, wr_off);

	dlsq_ram #(
		.WIDTH(EW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			occ_q  <= '0;
		end else begin
			if (cmd.pop) begin
				head_q <= (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
				occ_q  <= occ_q - CW'(1);
			end else if (cmd.wr_sel == WR_NEW) begin
				occ_q <= occ_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			tid_q <= s_tid;
			dur_q <= dur_norm;
			pos_q <= '0;
		end else if (cmd.walk_step) begin
			dur_q <= dur_q - rd_delta;
			pos_q <= pos_q + CW'(1);
		end
		if (cmd.fix_save) begin
			// The entry after the new one keeps the rest of its delta.
			fix_q <= {rd_delta - dur_q, rd_owner};
			idx_q <= occ_q;
		end else if (cmd.wr_sel == WR_SHIFT) begin
			idx_q <= idx_q - CW'(1);
		end
		if (cmd.pop) begin
			wake_q <= rd_owner;
		end
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_tid_q  <= cmd.emit_full ? tid_q : wake_q;
			out_last_q <= cmd.emit_last;
			out_full_q <= cmd.emit_full;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tid    = out_tid_q;
	assign m_last   = out_last_q;
	assign m_full   = out_full_q;

	always_comb begin
		sts.occ_zero   = (occ_q == '0);
		sts.full       = (occ_q == CW'(QUEUE_DEPTH));
		sts.out_free   = out_free;
		sts.walk_ge    = (dur_q >= rd_delta);
		sts.walk_last  = ((pos_q + CW'(1)) == occ_q);
		sts.shift_done = (idx_q == (pos_q + CW'(1)));
		sts.dec_one    = (rd_delta == TIME_BITS'(1));
		sts.peek_zero  = (rd_delta == '0);
	end

	`DLSQ_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CW'(QUEUE_DEPTH), "occupancy exceeds depth")
	`DLSQ_ASSERT_IMP(a_out_hold, clk, arst_n, out_valid_q && !m_tready, !cmd.emit, "result overwritten while stalled")
	`DLSQ_ASSERT_IMP(a_pop_nonempty, clk, arst_n, cmd.pop, occ_q != '0, "pop from empty queue")
	`DLSQ_ASSERT_NXT(a_ins_grow, clk, arst_n, cmd.wr_sel == WR_NEW, occ_q == $past(occ_q) + CW'(1), "insert did not grow queue")

endmodule
`default_nettype wire

@@ src/delta_list_sleep_queue_unit.sv @@
// Top level of the delta-list sleep queue: controller plus datapath.
//
//   Channel | Dir | tdata                            | tuser       | tlast
//   s_*     | in  | thread_id, duration (low first)  | op          | -
//   m_*     | out | woken_thread                     | queue_full  | last_in_run
//
// An add to an empty queue writes its entry directly, one to a full queue is rejected,
// and any other add reads the queued entries in order to find its place, then shifts
// the later entries up. A tick decrements the head delta and pops each expiring thread;
// on an empty queue it does nothing. These steps are set by the single read port
// of the entry RAM, whose data arrives in the cycle after the address. After reset
// the queue is empty and usable at once. A stalled result waits in the output register;
// the next transaction is taken once the controller is idle, and further results wait.
`default_nettype none
module delta_list_sleep_queue_unit #(
	parameter int QUEUE_DEPTH    = dlsq_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS      = dlsq_pkg::DEF_TIME_BITS,
	parameter int THREAD_ID_BITS = dlsq_pkg::DEF_THREAD_ID_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// thread_id, duration
	input  wire logic [((THREAD_ID_BITS + dlsq_pkg::DUR_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// op
	input  wire logic s_tuser,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// woken_thread
	output logic [((THREAD_ID_BITS + 7) / 8) * 8 - 1:0] m_tdata,
	output logic      m_tlast,
	// queue_full
	output logic      m_tuser
);

	import dlsq_pkg::*;

	localparam int OUT_W = ((THREAD_ID_BITS + 7) / 8) * 8;

	cmd_t                      cmd;
	sts_t                      sts;
	logic [THREAD_ID_BITS-1:0] m_tid;

	dlsq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.op      (s_tuser),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	dlsq_dp #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.TIME_BITS     (TIME_BITS),
		.THREAD_ID_BITS(THREAD_ID_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tid   (s_tdata[THREAD_ID_BITS-1:0]),
		.s_dur   (s_tdata[THREAD_ID_BITS +: DUR_BITS]),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.m_tid   (m_tid),
		.m_last  (m_tlast),
		.m_full  (m_tuser)
	);

	assign m_tdata = OUT_W'(m_tid);

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the delta-list sleep queue, with a wake-order scoreboard.
`timescale 1ns / 100ps
module testbench;
	import dlsq_pkg::*;

	localparam int QUEUE_DEPTH  = DEF_QUEUE_DEPTH;
	localparam int IN_WIDTH     = ((DEF_THREAD_ID_BITS + DUR_BITS + 7) / 8) * 8;
	localparam int OUT_WIDTH    = ((DEF_THREAD_ID_BITS + 7) / 8) * 8;
	localparam int RANDOM_ITEMS = 250;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 3000;
	localparam int TAIL_CYCLES  = 4 * QUEUE_DEPTH + 40;

	typedef struct packed {
		logic [7:0] thread;
		logic       is_last;
		logic       full;
	} wakeup_t;

	class wake_scoreboard;
		logic [31:0] delta_q [QUEUE_DEPTH];
		logic [7:0]  owner_q [QUEUE_DEPTH];
		int          count = 0;
		wakeup_t     wakeups_due [$];
		int          errors = 0;

		function int pending();
			return wakeups_due.size();
		endfunction

		function void flag(string what, wakeup_t want, wakeup_t got);
			errors++;
			if (errors <= 10)
				$display("%0t: %s: want thread %02h last %0b full %0b, %s %02h last %0b full %0b",
					$time, what, want.thread, want.is_last, want.full,
					"got thread", got.thread, got.is_last, got.full);
		endfunction

		// Works out the wakeups caused by one accepted request.
		function void note_request(logic op, logic [7:0] tid, logic [31:0] dur);
			logic [31:0] rem;
			int          pos;
			int          n;
			wakeup_t     w;
			if (op == OP_ADD) begin
				if (count >= QUEUE_DEPTH) begin
					w.thread  = tid;
					w.is_last = 1'b1;
					w.full    = 1'b1;
					wakeups_due.push_back(w);
					return;
				end
				rem = (dur == 32'd0) ? 32'd1 : dur;
				pos = 0;
				// Equal wake times go behind the entries already queued.
				while (pos < count && rem >= delta_q[pos]) begin
					rem = rem - delta_q[pos];
					pos++;
				end
				if (pos < count)
					delta_q[pos] = delta_q[pos] - rem;
				for (int i = count; i > pos; i--) begin
					delta_q[i] = delta_q[i - 1];
					owner_q[i] = owner_q[i - 1];
				end
				delta_q[pos] = rem;
				owner_q[pos] = tid;
				count++;
			end else if (count > 0) begin
				delta_q[0] = delta_q[0] - 32'd1;
				n = 0;
				while (n < count && delta_q[n] == 32'd0) begin
					w.thread  = owner_q[n];
					w.is_last = (n + 1 >= count) || (delta_q[n + 1] != 32'd0);
					w.full    = 1'b0;
					wakeups_due.push_back(w);
					n++;
				end
				for (int i = 0; i + n < count; i++) begin
					delta_q[i] = delta_q[i + n];
					owner_q[i] = owner_q[i + n];
				end
				count = count - n;
			end
		endfunction

		function void check_wakeup(logic [7:0] thread, logic is_last, logic full);
			wakeup_t got;
			wakeup_t want;
			got.thread  = thread;
			got.is_last = is_last;
			got.full    = full;
			if (wakeups_due.size() == 0) begin
				want = '0;
				flag("unexpected result", want, got);
			end else begin
				want = wakeups_due.pop_front();
				if (got.thread !== want.thread || got.is_last !== want.is_last ||
						got.full !== want.full)
					flag("mismatch", want, got);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_WIDTH-1:0]  s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_WIDTH-1:0] m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;

	wake_scoreboard sb;
	int             burst_left;
	int             huge_left;
	int             quiet_cycles;
	bit             hold_req;

	delta_list_sleep_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both channels are observed with the values they held before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_wakeup(m_tdata[7:0], m_tlast, m_tuser);
			if (s_tvalid && s_tready)
				sb.note_request(s_tuser, s_tdata[7:0], s_tdata[8 +: DUR_BITS]);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// The result side stalls on a rotating pattern that is redrawn now and then.
	initial begin
		logic [7:0] ready_pat;
		int         pat_left;
		m_tready = 1'b0;
		pat_left = 0;
		ready_pat = 8'hFF;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (pat_left == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pat = 8'hFF;
					1: ready_pat = 8'($urandom());
					2: ready_pat = 8'($urandom() & $urandom());
					default: ready_pat = 8'($urandom() | $urandom());
				endcase
				pat_left = $urandom_range(8, 64);
			end
			pat_left--;
			m_tready <= ready_pat[0];
			ready_pat = {ready_pat[0], ready_pat[7:1]};
		end
	end

	// Leaves tvalid high for the next transaction unless the burst is over and a gap is drawn.
	task automatic send_item(input logic op, input logic [7:0] tid, input logic [31:0] dur);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {dur, tid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
	endtask

	task automatic wait_all_woken();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_duration();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return 32'd0;
		if (r < 70)
			return $urandom_range(1, 4);
		if (r < 92)
			return $urandom_range(5, 30);
		if (r < 96)
			return $urandom_range(31, 300);
		if (huge_left > 0) begin
			huge_left--;
			return $urandom();
		end
		return $urandom_range(1, 4);
	endfunction

	initial begin
		int   mode;
		int   mode_left;
		logic op;
		sb = new;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = OP_ADD;
		s_tdata = '0;
		hold_req = 1'b0;
		quiet_cycles = 0;
		burst_left = $urandom_range(1, 12);
		huge_left = 4;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, zero duration, equal wake times and an insert in the middle.
		send_item(OP_TICK, 8'($urandom()), $urandom());
		send_item(OP_ADD, 8'h00, 32'd0);
		send_item(OP_ADD, 8'hFF, 32'd1);
		send_item(OP_ADD, 8'h5A, 32'd3);
		send_item(OP_ADD, 8'hA5, 32'd3);
		send_item(OP_ADD, 8'h07, 32'd2);
		send_item(OP_TICK, 8'($urandom()), $urandom());
		send_item(OP_TICK, 8'($urandom()), $urandom());
		send_item(OP_TICK, 8'($urandom()), $urandom());
		// A full queue that wakes in one tick, with one add rejected on the way.
		for (int k = 0; k < QUEUE_DEPTH; k++)
			send_item(OP_ADD, 8'(k * 17), (k % 2 == 0) ? 32'd0 : 32'd1);
		send_item(OP_ADD, 8'hC3, 32'hFFFF_FFFF);
		send_item(OP_TICK, 8'hFF, 32'hFFFF_FFFF);
		send_item(OP_ADD, 8'h33, 32'hFFFF_FFFF);
		wait_all_woken();

		mode = 0;
		mode_left = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(12, 32);
			end
			mode_left--;
			if (i == 90)
				hold_req = 1'b1;
			if (i == 180)
				wait_all_woken();
			case (mode)
				0: op = ($urandom_range(0, 99) < 85) ? OP_ADD : OP_TICK;
				1: op = ($urandom_range(0, 99) < 85) ? OP_TICK : OP_ADD;
				default: op = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_TICK;
			endcase
			if (op == OP_ADD)
				send_item(OP_ADD, 8'($urandom_range(0, 255)), pick_duration());
			else
				send_item(OP_TICK, 8'($urandom()), $urandom());
		end

		wait_all_woken();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
